// ===== rtl/core/ledpg_pkg.sv =====
// Shared types and constants of the LED strip mode pattern generator.
package ledpg_pkg;

    localparam logic [10:0] FIRST_ID       = 11'h401;
    localparam logic [10:0] LAST_ID        = 11'h407;
    localparam logic [4:0]  BLINK_LAST     = 5'd19;
    localparam logic [7:0]  ON_LEVEL_RESET = 8'd102;
    localparam logic [1:0]  REG_ON_LEVEL   = 2'd0;

    typedef enum logic [2:0] {
        MODE_RED_COMET   = 3'd0,
        MODE_GREEN_COMET = 3'd1,
        MODE_BLUE_COMET  = 3'd2,
        MODE_OFF         = 3'd3,
        MODE_SPLIT       = 3'd4,
        MODE_BLINK_DUAL  = 3'd5,
        MODE_BLINK_AMBER = 3'd6
    } mode_t;

    typedef enum logic {
        ACT_STATUS = 1'b0,
        ACT_FRAME  = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [10:0] message_id;
    } in_item_t;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic [7:0] blue_level;
        logic       last_led;
    } out_item_t;

    typedef struct packed {
        mode_t      mode;
        logic [5:0] head;
        logic       dark;
    } job_t;

endpackage

// ===== rtl/core/led_strip_mode_pattern_generator.sv =====
// Top level of the LED strip mode pattern generator.
// A status item (action 0) with identifier 0x401..0x407 selects display mode 0..6 and
// yields no output; a frame item (action 1) yields LED_COUNT colour items, index 0 first,
// last_led set on the final one, then advances the 16-bit step. Frame items are queued
// (two deep) so input and output stall independently; while m_ready holds, the renderer
// emits one LED per cycle, and back-to-back frames stream with no gap. Status items are
// taken only while the queue has room. on_level sits at byte address 0 of the APB port;
// it is to be written only while the block is idle, which the block itself does not enforce.
module led_strip_mode_pattern_generator import ledpg_pkg::*; #(
    parameter int LED_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item
);

    logic [7:0] on_level_reg;
    logic       fq_valid;
    logic       fq_ready;
    job_t       fq_job;
    logic       qb_valid;
    logic       qb_ready;
    job_t       qb_job;

    assign pready = 1'b1;
    assign prdata = {24'd0, on_level_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_level_reg <= ON_LEVEL_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_ON_LEVEL)) begin
            on_level_reg <= pwdata[7:0];
        end
    end

    ledpg_front #(.LED_COUNT(LED_COUNT)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    ledpg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    ledpg_back #(.LED_COUNT(LED_COUNT)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .on_level  (on_level_reg),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

// ===== rtl/core/ledpg_front.sv =====
// Front end: accepts items, tracks display mode and step, issues frame jobs.
module ledpg_front import ledpg_pkg::*; #(
    parameter int LED_COUNT = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     job_valid,
    input  logic     job_ready,
    output job_t     job
);

    localparam logic [5:0] LAST_HEAD = 6'(LED_COUNT - 1);

    mode_t       mode_reg;
    logic [15:0] step_reg;
    logic [5:0]  head_reg;
    logic [4:0]  sub_reg;
    logic        dark_reg;
    logic        take;
    logic        id_hit;

    assign s_ready   = job_ready;
    assign take      = s_valid && s_ready;
    assign id_hit    = (s_item.message_id >= FIRST_ID) && (s_item.message_id <= LAST_ID);
    assign job_valid = take && (s_item.action == ACT_FRAME);
    assign job       = '{mode: mode_reg, head: head_reg, dark: dark_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RED_COMET;
            step_reg <= '0;
            head_reg <= '0;
            sub_reg  <= '0;
            dark_reg <= 1'b0;
        end else if (take) begin
            if (s_item.action == ACT_STATUS) begin
                if (id_hit) begin
                    mode_reg <= mode_t'(3'(s_item.message_id - FIRST_ID));
                end
            end else begin
                // wrap: every counter derived from the step restarts at zero
                if (step_reg == 16'hFFFF) begin
                    step_reg <= '0;
                    head_reg <= '0;
                    sub_reg  <= '0;
                    dark_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 16'd1;
                    head_reg <= (head_reg == LAST_HEAD) ? 6'd0 : head_reg + 6'd1;
                    if (sub_reg == BLINK_LAST) begin
                        sub_reg  <= '0;
                        dark_reg <= ~dark_reg;
                    end else begin
                        sub_reg <= sub_reg + 5'd1;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/ledpg_queue.sv =====
// Two-entry job queue between front end and renderer.
module ledpg_queue import ledpg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/ledpg_back.sv =====
// Renderer: walks the strip one LED per unstalled cycle, registering each colour item.
module ledpg_back import ledpg_pkg::*; #(
    parameter int LED_COUNT = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] on_level,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);
    localparam logic [6:0] N7       = 7'(LED_COUNT);
    localparam logic [6:0] H7       = 7'(LED_COUNT / 2);

    job_t      job_reg;
    logic      busy_reg;
    logic [5:0] idx_reg;
    logic      m_valid_reg;
    out_item_t out_reg;
    logic      advance;
    logic      last;
    logic [6:0] diff;
    logic [6:0] gap;
    logic      near;
    logic      low_half;
    logic      r_on;
    logic      g_on;
    logic      b_on;

    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign last      = (idx_reg == LAST_IDX);
    assign job_ready = !busy_reg || (advance && last);
    assign m_valid   = m_valid_reg;
    assign m_item    = out_reg;

    always_comb begin
        diff     = {1'b0, idx_reg} - {1'b0, job_reg.head};
        gap      = diff[6] ? diff + N7 : diff;
        near     = gap < H7;
        low_half = {1'b0, idx_reg} < H7;
        r_on     = 1'b0;
        g_on     = 1'b0;
        b_on     = 1'b0;
        case (job_reg.mode)
            MODE_RED_COMET:   r_on = near;
            MODE_GREEN_COMET: g_on = near;
            MODE_BLUE_COMET:  b_on = near;
            MODE_SPLIT: begin
                r_on = near;
                g_on = near;
                b_on = !near;
            end
            MODE_BLINK_DUAL: begin
                b_on = !job_reg.dark && near && low_half;
                r_on = !job_reg.dark && near && !low_half;
                g_on = r_on;
            end
            MODE_BLINK_AMBER: begin
                r_on = !job_reg.dark && near;
                g_on = r_on;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            job_reg <= job;
        end
        if (advance) begin
            out_reg.led_index   <= idx_reg;
            out_reg.green_level <= g_on ? on_level : 8'd0;
            out_reg.red_level   <= r_on ? on_level : 8'd0;
            out_reg.blue_level  <= b_on ? on_level : 8'd0;
            out_reg.last_led    <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (job_valid && job_ready) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (advance) begin
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 6'd1;
                end
            end
        end
    end

endmodule
